[rtl/core/stkfr_pkg.sv]
// Shared types and constants for the framed serial command receiver.
package stkfr_pkg;

  localparam logic [7:0]  START_BYTE = 8'h1B;
  localparam logic [7:0]  TOKEN_BYTE = 8'h0E;
  localparam logic [15:0] TICK_MAX   = 16'hFFFF;

  localparam logic [15:0] MAX_BODY_RESET = 16'd275;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BODY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT  = 2'd1;

  localparam logic       CMD_BYTE  = 1'b0;
  localparam logic       CMD_TICK  = 1'b1;
  localparam logic       KIND_BODY = 1'b0;
  localparam logic       KIND_END  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CKSUM   = 2'd1;
  localparam logic [1:0] ST_PACKERR = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SEQ    = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_TOKEN  = 3'd4,
    PH_DATA   = 3'd5,
    PH_CHECK  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [15:0] max_body_size;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    logic [1:0]  frame_status;
    logic [7:0]  seq_number;
    logic [15:0] body_length;
  } result_t;

endpackage

[rtl/core/stkfr_parser.sv]
// Frame parser: phase register, running checksum, counters and result decode.
module stkfr_parser (
  input  logic            clk,
  input  logic            rst,
  input  stkfr_pkg::cfg_t cfg,
  input  logic            accept,
  input  logic            cmd,
  input  logic [7:0]      rx_byte,
  output logic            res_valid,
  output stkfr_pkg::result_t res
);
  import stkfr_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  seq_reg, seq_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] body_count, body_count_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  logic [15:0] ticks_inc;
  logic [15:0] count_inc;
  logic [15:0] length_full;
  logic        clear;

  assign ticks_inc   = (idle_ticks < TICK_MAX) ? idle_ticks + 16'd1 : idle_ticks;
  assign count_inc   = body_count + 16'd1;
  assign length_full = {length_reg[15:8], rx_byte};

  always_ff @(posedge clk) begin
    if (rst || (accept && clear)) begin
      phase       <= PH_IDLE;
      seq_reg     <= '0;
      length_reg  <= '0;
      body_count  <= '0;
      running_xor <= '0;
      idle_ticks  <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      seq_reg     <= seq_reg_next;
      length_reg  <= length_reg_next;
      body_count  <= body_count_next;
      running_xor <= running_xor_next;
      idle_ticks  <= idle_ticks_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    seq_reg_next     = seq_reg;
    length_reg_next  = length_reg;
    body_count_next  = body_count;
    running_xor_next = running_xor;
    idle_ticks_next  = idle_ticks;
    clear            = 1'b0;
    res_valid        = 1'b0;
    res.kind         = KIND_END;
    res.body_byte    = '0;
    res.frame_status = ST_OK;
    res.seq_number   = seq_reg;
    res.body_length  = length_reg;

    if (cmd == CMD_TICK) begin
      // Silence is only counted once a frame has started.
      if (phase != PH_IDLE) begin
        idle_ticks_next = ticks_inc;
        if (ticks_inc >= cfg.timeout_ticks) begin
          res_valid        = 1'b1;
          res.frame_status = ST_TIMEOUT;
          clear            = 1'b1;
        end
      end
    end else begin
      idle_ticks_next = '0;
      unique case (phase)
        PH_IDLE: begin
          if (rx_byte != START_BYTE) begin
            res_valid        = 1'b1;
            res.frame_status = ST_PACKERR;
            clear            = 1'b1;
          end else begin
            running_xor_next = START_BYTE;
            phase_next       = PH_SEQ;
          end
        end
        PH_SEQ: begin
          seq_reg_next     = rx_byte;
          running_xor_next = running_xor ^ rx_byte;
          phase_next       = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          length_reg_next  = {rx_byte, 8'h00};
          running_xor_next = running_xor ^ rx_byte;
          phase_next       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_reg_next  = length_full;
          running_xor_next = running_xor ^ rx_byte;
          if (length_full >= cfg.max_body_size) begin
            res_valid        = 1'b1;
            res.frame_status = ST_PACKERR;
            res.body_length  = length_full;
            clear            = 1'b1;
          end else begin
            body_count_next = '0;
            phase_next      = PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          if (rx_byte != TOKEN_BYTE) begin
            res_valid        = 1'b1;
            res.frame_status = ST_PACKERR;
            clear            = 1'b1;
          end else begin
            running_xor_next = running_xor ^ rx_byte;
            phase_next       = (length_reg == 16'd0) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          running_xor_next = running_xor ^ rx_byte;
          body_count_next  = count_inc;
          if (count_inc >= length_reg) begin
            phase_next = PH_CHECK;
          end
          res_valid     = 1'b1;
          res.kind      = KIND_BODY;
          res.body_byte = rx_byte;
        end
        PH_CHECK: begin
          res_valid        = 1'b1;
          res.frame_status = (running_xor == rx_byte) ? ST_OK : ST_CKSUM;
          clear            = 1'b1;
        end
        default: begin
          clear = 1'b1;
        end
      endcase
    end
  end

endmodule

[rtl/core/stkfr_out_reg.sv]
// Result register that decouples the output beat from input acceptance.
module stkfr_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               res_valid,
  input  stkfr_pkg::result_t res,
  input  logic               out_ready,
  output logic               out_valid,
  output stkfr_pkg::result_t out_res,
  output logic               take
);
  import stkfr_pkg::*;

  // A new beat may enter whenever the held result is gone or leaves now.
  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_res <= res;
    end
  end

endmodule

[rtl/core/stk500v2_frame_receiver_core.sv]
// Top level of the framed serial command receiver.
// A result is registered as its input beat is accepted and is visible at out_valid in the next cycle.
// Throughput: one input beat per cycle; the result register frees as its beat is taken.
// in_ready drops only while a held result is stalled by out_ready.
// Reset: synchronous rst clears the parser to idle and loads the register defaults.
module stk500v2_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  body_byte,
  output logic [1:0]  frame_status,
  output logic [7:0]  seq_number,
  output logic [15:0] body_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [stkfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import stkfr_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    accept;
  logic    take;

  assign cfg_ready = 1'b1;
  assign in_ready  = take;
  assign accept    = in_valid && take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_body_size <= MAX_BODY_RESET;
      cfg.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_BODY: cfg.max_body_size <= cfg_data;
        REG_TIMEOUT:  cfg.timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  stkfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .cmd       (cmd),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  stkfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .take      (take)
  );

  assign kind         = out_res.kind;
  assign body_byte    = out_res.body_byte;
  assign frame_status = out_res.frame_status;
  assign seq_number   = out_res.seq_number;
  assign body_length  = out_res.body_length;

endmodule

[rtl/core/stkfr_checker.sv]
// Port-level checks for the frame receiver, bound to its top level.
module stkfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [7:0]  body_byte,
  input logic [1:0]  frame_status,
  input logic [7:0]  seq_number,
  input logic [15:0] body_length
);
  import stkfr_pkg::*;

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(body_byte)
      && $stable(frame_status) && $stable(seq_number) && $stable(body_length))
    else $error("stalled result beat changed");

  // Input is refused only while a result is held back.
  assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow result register");

  // Body beats carry no status, end beats carry no body byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_BODY) ? (frame_status == ST_OK) : (body_byte == 8'h00))
    else $error("result fields inconsistent with kind");

  // Nothing is presented in the cycle after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stk500v2_frame_receiver_core stkfr_checker u_stkfr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .body_byte    (body_byte),
  .frame_status (frame_status),
  .seq_number   (seq_number),
  .body_length  (body_length)
);

[bench/stk500v2_frame_receiver_core_tb.sv]
// Self-checking testbench for the framed serial command receiver core.
`timescale 1ns / 100ps

module stk500v2_frame_receiver_core_tb;
  import stkfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum int {
    FLAW_NONE,
    FLAW_CKSUM,
    FLAW_TOKEN,
    FLAW_OVERSIZE,
    FLAW_TIMEOUT
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_BYTE;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  body_byte;
  logic [1:0]  frame_status;
  logic [7:0]  seq_number;
  logic [15:0] body_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_MAX_BODY;
  logic [15:0] cfg_data = 16'h0000;

  // Receiver state as the testbench expects it to evolve.
  phase_t      rx_phase;
  logic [7:0]  rx_seq;
  logic [15:0] rx_len;
  logic [15:0] rx_count;
  logic [7:0]  rx_xor;
  logic [15:0] rx_silence;
  logic [15:0] max_body_q;
  logic [15:0] timeout_q;

  result_t     frame_results_due[$];
  bit          quiet = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned errors = 0;
  int unsigned body_seen = 0;
  int unsigned ends_seen[4] = '{0, 0, 0, 0};
  int unsigned cycle_count = 0;

  stk500v2_frame_receiver_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .body_byte    (body_byte),
    .frame_status (frame_status),
    .seq_number   (seq_number),
    .body_length  (body_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, frame_results_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic clear_frame_state();
    rx_phase   = PH_IDLE;
    rx_seq     = 8'h00;
    rx_len     = 16'h0000;
    rx_count   = 16'h0000;
    rx_xor     = 8'h00;
    rx_silence = 16'h0000;
  endtask

  task automatic close_frame(input logic [1:0] status);
    result_t r;
    r.kind         = KIND_END;
    r.body_byte    = 8'h00;
    r.frame_status = status;
    r.seq_number   = rx_seq;
    r.body_length  = rx_len;
    frame_results_due.push_back(r);
    clear_frame_state();
  endtask

  // Advances the expected receiver state by one accepted input beat.
  task automatic track_frame(input logic c, input logic [7:0] b);
    result_t r;
    if (c == CMD_TICK) begin
      if (rx_phase != PH_IDLE) begin
        if (rx_silence != TICK_MAX) rx_silence = rx_silence + 16'd1;
        if (rx_silence >= timeout_q) close_frame(ST_TIMEOUT);
      end
    end else begin
      rx_silence = 16'h0000;
      case (rx_phase)
        PH_IDLE: begin
          if (b != START_BYTE) begin
            close_frame(ST_PACKERR);
          end else begin
            rx_xor   = START_BYTE;
            rx_phase = PH_SEQ;
          end
        end
        PH_SEQ: begin
          rx_seq   = b;
          rx_xor   = rx_xor ^ b;
          rx_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          rx_len   = {b, 8'h00};
          rx_xor   = rx_xor ^ b;
          rx_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          rx_len[7:0] = b;
          rx_xor      = rx_xor ^ b;
          if (rx_len >= max_body_q) begin
            close_frame(ST_PACKERR);
          end else begin
            rx_count = 16'h0000;
            rx_phase = PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          if (b != TOKEN_BYTE) begin
            close_frame(ST_PACKERR);
          end else begin
            rx_xor   = rx_xor ^ b;
            rx_phase = (rx_len == 16'h0000) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          rx_xor   = rx_xor ^ b;
          rx_count = rx_count + 16'd1;
          if (rx_count >= rx_len) rx_phase = PH_CHECK;
          r.kind         = KIND_BODY;
          r.body_byte    = b;
          r.frame_status = ST_OK;
          r.seq_number   = rx_seq;
          r.body_length  = rx_len;
          frame_results_due.push_back(r);
        end
        PH_CHECK: begin
          close_frame((rx_xor == b) ? ST_OK : ST_CKSUM);
        end
        default: begin
          clear_frame_state();
        end
      endcase
    end
  endtask

  // Sends one input beat. Valid stays high on return so back-to-back beats
  // need no extra assignment.
  task automatic send_beat(input logic c, input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    rx_byte  <= b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    if (!(c == CMD_TICK && rx_phase == PH_IDLE)) beats_sent++;
    track_frame(c, b);
    @(posedge clk);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Stops input and waits until every expected result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MAX_BODY) max_body_q = data;
    else if (idx == REG_TIMEOUT) timeout_q = data;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] max_body, input logic [15:0] ticks);
    drain_results();
    write_reg(REG_MAX_BODY, max_body);
    write_reg(REG_TIMEOUT, ticks);
  endtask

  // Builds a frame, spoils it as asked and sends it with short tick gaps.
  task automatic send_frame(input logic [7:0] seq, input logic [15:0] len, input flaw_t flaw);
    logic [7:0]  frame_q[$];
    logic [7:0]  sum;
    int unsigned cut;
    int unsigned gap_max;
    frame_q = {START_BYTE, seq, len[15:8], len[7:0]};
    if (flaw == FLAW_TOKEN) begin
      sum = 8'($urandom_range(0, 255));
      frame_q.push_back((sum == TOKEN_BYTE) ? ~sum : sum);
    end else if (flaw != FLAW_OVERSIZE) begin
      frame_q.push_back(TOKEN_BYTE);
      repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
      sum = 8'h00;
      foreach (frame_q[i]) sum = sum ^ frame_q[i];
      if (flaw == FLAW_CKSUM) sum = sum ^ 8'($urandom_range(1, 255));
      frame_q.push_back(sum);
    end
    cut = (flaw == FLAW_TIMEOUT) ? $urandom_range(1, frame_q.size() - 1) : frame_q.size();
    gap_max = (timeout_q - 1 < 40) ? timeout_q - 1 : 40;
    for (int i = 0; i < cut; i++) begin
      if (i > 0 && gap_max > 0 && $urandom_range(0, 4) == 0)
        send_ticks($urandom_range(1, gap_max));
      send_beat(CMD_BYTE, frame_q[i]);
    end
    if (flaw == FLAW_TIMEOUT) send_ticks(timeout_q);
  endtask

  task automatic test_idle_noise();
    send_ticks(2);
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, 8'hFF);
  endtask

  task automatic test_good_frames();
    send_frame(8'hFF, 16'd0, FLAW_NONE);
    send_frame(8'h00, 16'd2, FLAW_NONE);
    send_frame(8'h5A, 16'd1, FLAW_CKSUM);
  endtask

  task automatic test_packet_errors();
    send_frame(8'h33, 16'd1, FLAW_TOKEN);
    send_frame(8'h44, MAX_BODY_RESET, FLAW_OVERSIZE);
    send_frame(8'hC3, 16'hFFFF, FLAW_OVERSIZE);
  endtask

  task automatic test_timeouts();
    set_config(MAX_BODY_RESET, 16'd1);
    send_beat(CMD_BYTE, START_BYTE);
    send_beat(CMD_TICK, 8'hFF);
    send_beat(CMD_BYTE, START_BYTE);
    send_beat(CMD_BYTE, 8'h07);
    send_beat(CMD_BYTE, 8'h12);
    send_beat(CMD_TICK, 8'h00);
    // Each byte clears the silence count, so single ticks between bytes pass.
    set_config(MAX_BODY_RESET, 16'd2);
    send_beat(CMD_BYTE, START_BYTE);
    send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_BYTE, 8'h09);
    send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_BYTE, 8'h00);
    send_ticks(2);
  endtask

  task automatic test_register_extremes();
    set_config(16'd1, 16'd3);
    send_frame(8'h11, 16'd0, FLAW_NONE);
    send_frame(8'h22, 16'd1, FLAW_OVERSIZE);
    set_config(16'hFFFF, 16'd3);
    send_frame(8'h66, 16'hFFFF, FLAW_OVERSIZE);
    // Largest legal length; the body is cut short by a timeout.
    send_beat(CMD_BYTE, START_BYTE);
    send_beat(CMD_BYTE, 8'h77);
    send_beat(CMD_BYTE, 8'hFF);
    send_beat(CMD_BYTE, 8'hFE);
    send_beat(CMD_BYTE, TOKEN_BYTE);
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, 8'hFF);
    send_ticks(3);
    set_config(16'hFFFF, 16'hFFFF);
    send_beat(CMD_BYTE, START_BYTE);
    send_ticks(300);
    send_beat(CMD_BYTE, 8'hA5);
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, 8'h01);
    send_beat(CMD_BYTE, TOKEN_BYTE);
    send_beat(CMD_BYTE, 8'h5A);
    send_beat(CMD_BYTE, START_BYTE ^ 8'hA5 ^ 8'h01 ^ TOKEN_BYTE ^ 8'h5A);
  endtask

  task automatic run_random_phase(input int unsigned beats);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned short_max;
    logic [15:0] len;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      short_max = (max_body_q - 1 < 12) ? max_body_q - 1 : 12;
      if ($urandom_range(0, 19) == 0) len = 16'($urandom_range(0, max_body_q - 1));
      else len = 16'($urandom_range(0, short_max));
      if (pick < 68) begin
        send_frame(8'($urandom_range(0, 255)), len, FLAW_NONE);
      end else if (pick < 78) begin
        send_frame(8'($urandom_range(0, 255)), len, FLAW_CKSUM);
      end else if (pick < 84) begin
        send_frame(8'($urandom_range(0, 255)), len, FLAW_TOKEN);
      end else if (pick < 90) begin
        if ($urandom_range(0, 3) == 0 || max_body_q > 16'hFFEB) len = 16'hFFFF;
        else len = 16'($urandom_range(max_body_q, max_body_q + 20));
        send_frame(8'($urandom_range(0, 255)), len, FLAW_OVERSIZE);
      end else if (pick < 95) begin
        send_frame(8'($urandom_range(0, 255)), len, FLAW_TIMEOUT);
      end else begin
        repeat ($urandom_range(1, 4))
          send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        // Noise can leave a frame open; let it time out before the next one.
        while (rx_phase != PH_IDLE) send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_random_traffic();
    set_config(16'($urandom_range(8, 64)), 16'($urandom_range(2, 30)));
    run_random_phase(250);
    set_config(16'($urandom_range(1, 4)), 16'($urandom_range(2, 10)));
    run_random_phase(200);
    set_config(MAX_BODY_RESET, 16'($urandom_range(2, 30)));
    run_random_phase(250);
    set_config(16'($urandom_range(16, 300)), 16'($urandom_range(5, 30)));
    quiet = 1'b1;
    run_random_phase(300);
  endtask

  // Result side stalls in random bursts until the quiet part of the run.
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // A result beat is taken at the next rising edge when valid and ready are
  // both high at the falling edge before it.
  always @(negedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (frame_results_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result beat: kind=%0b byte=%02h status=%0d seq=%02h len=%04h",
                   kind, body_byte, frame_status, seq_number, body_length);
      end else begin
        want = frame_results_due.pop_front();
        if (kind !== want.kind || body_byte !== want.body_byte ||
            frame_status !== want.frame_status || seq_number !== want.seq_number ||
            body_length !== want.body_length) begin
          errors++;
          if (errors <= 10)
            $display({"Mismatch: expected kind=%0b byte=%02h status=%0d seq=%02h len=%04h,",
                      " got kind=%0b byte=%02h status=%0d seq=%02h len=%04h"},
                     want.kind, want.body_byte, want.frame_status, want.seq_number,
                     want.body_length, kind, body_byte, frame_status, seq_number,
                     body_length);
        end
        if (want.kind == KIND_BODY) body_seen++;
        else ends_seen[want.frame_status]++;
      end
    end
  end

  initial begin
    max_body_q = MAX_BODY_RESET;
    timeout_q  = TIMEOUT_RESET;
    clear_frame_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_noise();
    test_good_frames();
    test_packet_errors();
    test_timeouts();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d input beats over ten register settings; checked %0d body bytes",
             beats_sent, body_seen);
    $display("and frame ends: %0d ok, %0d checksum, %0d packet error, %0d timeout.",
             ends_seen[ST_OK], ends_seen[ST_CKSUM], ends_seen[ST_PACKERR],
             ends_seen[ST_TIMEOUT]);
    if (errors == 0 && frame_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures, %0d results never arrived", errors, frame_results_due.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/stkfr_pkg.sv
rtl/core/stkfr_parser.sv
rtl/core/stkfr_out_reg.sv
rtl/core/stk500v2_frame_receiver_core.sv
rtl/core/stkfr_checker.sv
bench/stk500v2_frame_receiver_core_tb.sv
